>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the noise unit.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FBM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define FBM_ASSERT_NEVER(lbl, cond) `FBM_ASSERT(lbl, !(cond))
`else
`define FBM_ASSERT(lbl, prop)
`define FBM_ASSERT_NEVER(lbl, cond)
`endif
`endif

>>> rtl/core/fbmvn_pkg.sv
package fbmvn_pkg;

  localparam int unsigned MaxOctaves = 8;
  localparam int unsigned DefOctaves = 4;
  localparam int unsigned CoordW = 32;
  localparam int unsigned FreqW = 16;
  localparam int unsigned ValW = 16;
  localparam int unsigned ProdW = CoordW + FreqW + 1;
  localparam int unsigned SumW = 35;
  localparam int unsigned LaneLat = 5;
  localparam logic [FreqW-1:0] FreqReset = 16'd6554;

  localparam logic [31:0] HashKx = 32'd374761393;
  localparam logic [31:0] HashKy = 32'd668265263;
  localparam logic [31:0] HashKm = 32'd1274126177;

  // Q1.16 amplitude of each octave, falling by 0.55 per octave.
  function automatic logic [16:0] amp_of(input int unsigned idx);
    logic [16:0] a;
    a = 17'd0;
    unique case (idx)
      0: a = 17'd65536;
      1: a = 17'd36045;
      2: a = 17'd19825;
      3: a = 17'd10904;
      4: a = 17'd5997;
      5: a = 17'd3298;
      6: a = 17'd1814;
      7: a = 17'd998;
      default: a = 17'd0;
    endcase
    return a;
  endfunction

  function automatic int unsigned norm_of(input int unsigned n);
    int unsigned s;
    s = 0;
    for (int unsigned i = 0; i < n; i++) begin
      s = s + int'(amp_of(i));
    end
    return s;
  endfunction

  // Smoothstep weight from the fraction t and its registered square t2.
  function automatic logic [15:0] smooth_w(input logic [15:0] t, input logic [15:0] t2);
    logic [17:0] k;
    logic [33:0] p;
    k = 18'd196608 - {1'b0, t, 1'b0};
    p = 34'(t2) * 34'(k);
    return p[31:16];
  endfunction

  function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] w);
    logic [16:0] iw;
    logic [32:0] pa;
    logic [32:0] pb;
    logic [32:0] s;
    iw = 17'h10000 - {1'b0, w};
    pa = 33'(a) * 33'(iw);
    pb = 33'(b) * 33'(w);
    s = pa + pb;
    return s[31:16];
  endfunction

endpackage

>>> rtl/core/fbmvn_octave.sv
module fbmvn_octave #(
  parameter int unsigned OCT_IDX = 0
) (
  input  logic                                clk_i,
  input  logic signed [fbmvn_pkg::ProdW-1:0]  px_i,
  input  logic signed [fbmvn_pkg::ProdW-1:0]  py_i,
  output logic        [fbmvn_pkg::ValW-1:0]   noise_o
);
  import fbmvn_pkg::*;

  logic signed [63:0] sx_ext, sy_ext, sx_sh, sy_sh;
  logic [31:0] cx, cy;
  logic [15:0] fx, fy;
  logic [31:0] sqx, sqy;

  logic [31:0] mx_q, my_q, mx_d, my_d;
  logic [15:0] fx_q, fy_q, tx2_q, ty2_q;

  logic [31:0] g_d [4];
  logic [31:0] g_q [4];
  logic [15:0] wx_q, wy_q, wx2_q, wy2_q, wy3_q;

  logic [31:0] hm_q [4];
  logic [15:0] v [4];
  logic [15:0] lo_q, hi_q, noise_q;

  // Scale by the octave frequency: the shift stands for the extra octave doubling.
  always_comb begin
    sx_ext = 64'(px_i);
    sy_ext = 64'(py_i);
    sx_sh = sx_ext <<< OCT_IDX;
    sy_sh = sy_ext <<< OCT_IDX;
    cx = sx_sh[63:32];
    cy = sy_sh[63:32];
    fx = sx_sh[31:16];
    fy = sy_sh[31:16];
    mx_d = cx * HashKx;
    my_d = cy * HashKy;
    sqx = 32'(fx) * 32'(fx);
    sqy = 32'(fy) * 32'(fy);
  end

  // Neighbor cells add one, so their products differ from ours by the key.
  always_comb begin
    logic [31:0] ax, ay, h;
    for (int c = 0; c < 4; c++) begin
      ax = (c % 2 == 1) ? mx_q + HashKx : mx_q;
      ay = (c / 2 == 1) ? my_q + HashKy : my_q;
      h = ax ^ ay;
      g_d[c] = h ^ (h >> 13);
    end
  end

  always_comb begin
    logic [31:0] f;
    for (int c = 0; c < 4; c++) begin
      f = hm_q[c] ^ (hm_q[c] >> 16);
      v[c] = f[23:8];
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q <= mx_d;
    my_q <= my_d;
    fx_q <= fx;
    fy_q <= fy;
    tx2_q <= sqx[31:16];
    ty2_q <= sqy[31:16];
    for (int c = 0; c < 4; c++) begin
      g_q[c] <= g_d[c];
      hm_q[c] <= g_q[c] * HashKm;
    end
    wx_q <= smooth_w(fx_q, tx2_q);
    wy_q <= smooth_w(fy_q, ty2_q);
    wx2_q <= wx_q;
    wy2_q <= wy_q;
    lo_q <= blend(v[0], v[1], wx2_q);
    hi_q <= blend(v[2], v[3], wx2_q);
    wy3_q <= wy2_q;
    noise_q <= blend(lo_q, hi_q, wy3_q);
  end

  assign noise_o = noise_q;

endmodule

>>> rtl/core/fbmvn_cdiv.sv
`include "assert_macros.svh"
module fbmvn_cdiv #(
  parameter int unsigned DIVISOR = 1,
  parameter int unsigned DW = 35
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic [DW-1:0]                      dividend_i,
  output logic                               out_valid_o,
  output logic [fbmvn_pkg::ValW-1:0]         quotient_o
);
  import fbmvn_pkg::*;

  localparam logic [DW-1:0] Dv = DW'(DIVISOR);

  // Rounded-up reciprocal, scaled so that the truncated product is the exact
  // quotient for every DW-bit dividend.
  localparam int unsigned Lg = $clog2(DIVISOR);
  localparam int unsigned Sh = DW + Lg;
  localparam logic [63:0] Recip = ((64'd1 << Sh) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam int unsigned RW = DW + 1;
  localparam int unsigned LoW = RW / 2;
  localparam int unsigned HiW = RW - LoW;
  localparam logic [LoW-1:0] RecipLo = Recip[LoW-1:0];
  localparam logic [HiW-1:0] RecipHi = Recip[RW-1:LoW];

  logic [DW+LoW-1:0] plo_d, plo_q;
  logic [DW+HiW-1:0] phi_d, phi_q;
  logic [DW+HiW:0]   acc;
  logic [DW+HiW:0]   qwide;
  logic [ValW-1:0]   quot_d, quot_q;
  logic [1:0]        vld_q;

  // The first stage forms the two halves of the reciprocal product; the second
  // stage joins them and keeps the quotient bits.
  always_comb begin
    plo_d = (DW+LoW)'(dividend_i) * (DW+LoW)'(RecipLo);
    phi_d = (DW+HiW)'(dividend_i) * (DW+HiW)'(RecipHi);
    acc = (DW+HiW+1)'(phi_q) + (DW+HiW+1)'(plo_q >> LoW);
    qwide = acc >> (Sh - LoW);
    quot_d = qwide[ValW-1:0];
  end

  always_ff @(posedge clk_i) begin
    plo_q <= plo_d;
    phi_q <= phi_d;
    quot_q <= quot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[1];
  assign quotient_o = quot_q;

  `FBM_ASSERT(a_div_in_range, in_valid_i |-> dividend_i < (Dv << ValW))
  `FBM_ASSERT_NEVER(a_div_quot_fits, vld_q[0] && ((qwide >> ValW) != '0))
  `FBM_ASSERT(a_div_vld_seq, vld_q[0] |=> vld_q[1])

endmodule

>>> rtl/core/fbm_value_noise_unit.sv
// Fractal value noise in 10 register stages; valid_o marks each result that leaves them:
// one for scaling, five in each octave lane, two for weighting and summing, two to divide.
// Throughput is one word per clock; busy stays low, and a new word may start every cycle.
// Results are strobed for one cycle by valid_o; the receiver cannot stall them.
// Reset (rst_ni low, asynchronous) clears all valid bits and sets base_q to 6554.
`include "assert_macros.svh"
module fbm_value_noise_unit #(
  parameter int unsigned OCTAVES = fbmvn_pkg::DefOctaves
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               cfg_we_i,
  input  logic [fbmvn_pkg::FreqW-1:0]        cfg_wdata_i,
  input  logic signed [fbmvn_pkg::CoordW-1:0] coord_x_i,
  input  logic signed [fbmvn_pkg::CoordW-1:0] coord_y_i,
  output logic                               valid_o,
  output logic [fbmvn_pkg::ValW-1:0]         noise_value_o
);
  import fbmvn_pkg::*;

  // The octave count is clamped to the range the amplitude table covers.
  localparam int unsigned NumOct = (OCTAVES < 1) ? 1 :
                                   (OCTAVES > MaxOctaves) ? MaxOctaves : OCTAVES;
  // The normalization is the sum of the amplitudes in use, fixed at elaboration.
  localparam int unsigned Norm = norm_of(NumOct);

  logic [FreqW-1:0] base_q;

  // Stage 1: the coordinate times the first-octave frequency, kept exact.
  logic signed [ProdW-1:0] px_q, py_q;
  logic                    s1_vld_q;

  // Stages 2 through 6 live in the octave lanes, one lane per octave.
  logic [ValW-1:0]    lane_noise [NumOct];
  logic [LaneLat-1:0] lane_vld_q;

  // Stage 7: each octave value weighted by its amplitude.
  logic [32:0] wn_q [NumOct];
  logic        wn_vld_q;

  // Stage 8: the weighted sum plus half the divisor, so that the division rounds.
  logic [SumW-1:0] sum_d, sum_q;
  logic            sum_vld_q;

  // The pipeline never holds, so the block is always ready for a new word.
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= FreqReset;
      s1_vld_q <= 1'b0;
      lane_vld_q <= '0;
      wn_vld_q <= 1'b0;
      sum_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      s1_vld_q <= start && !busy;
      lane_vld_q <= {lane_vld_q[LaneLat-2:0], s1_vld_q};
      wn_vld_q <= lane_vld_q[LaneLat-1];
      sum_vld_q <= wn_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= coord_x_i * $signed({1'b0, base_q});
    py_q <= coord_y_i * $signed({1'b0, base_q});
  end

  for (genvar o = 0; o < NumOct; o++) begin : g_oct
    fbmvn_octave #(
      .OCT_IDX(o)
    ) u_octave (
      .clk_i  (clk_i),
      .px_i   (px_q),
      .py_i   (py_q),
      .noise_o(lane_noise[o])
    );

    always_ff @(posedge clk_i) begin
      wn_q[o] <= 33'(amp_of(o)) * 33'(lane_noise[o]);
    end
  end

  // At most eight terms, summed in one adder tree.
  always_comb begin
    sum_d = SumW'(Norm / 2);
    for (int o = 0; o < NumOct; o++) begin
      sum_d = sum_d + SumW'(wn_q[o]);
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  // Division by the constant normalization through a reciprocal multiply,
  // split over two stages.
  fbmvn_cdiv #(
    .DIVISOR(Norm),
    .DW     (SumW)
  ) u_cdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sum_vld_q),
    .dividend_i (sum_q),
    .out_valid_o(valid_o),
    .quotient_o (noise_value_o)
  );

  `FBM_ASSERT(a_sum_bounded, sum_vld_q |-> sum_q < (SumW'(Norm) << ValW))

endmodule

>>> bench/fbm_value_noise_unit_tb.sv
`timescale 1ns / 100ps

module fbm_value_noise_unit_tb;
  import fbmvn_pkg::*;

  localparam int unsigned NumOctaves = DefOctaves;
  localparam int unsigned RandomWords = 1950;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned WatchdogLimit = 2000;

  // Keeps the expected noise levels in the order their words were accepted.
  class noise_scoreboard;
    logic [ValW-1:0] pending_levels[$];

    function void note_word(input logic [ValW-1:0] level);
      pending_levels.push_back(level);
    endfunction

    function void check_level(input logic [ValW-1:0] got, output bit bad,
                              output logic [ValW-1:0] want, output bit orphan);
      bad = 1'b0;
      orphan = 1'b0;
      want = '0;
      if (pending_levels.size() == 0) begin
        orphan = 1'b1;
        bad = 1'b1;
      end else begin
        want = pending_levels.pop_front();
        bad = (want !== got);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic cfg_we_i;
  logic [FreqW-1:0] cfg_wdata_i;
  logic signed [CoordW-1:0] coord_x_i;
  logic signed [CoordW-1:0] coord_y_i;
  logic valid_o;
  logic [ValW-1:0] noise_value_o;

  noise_scoreboard levels_sb;
  logic [FreqW-1:0] model_freq;
  int unsigned idle_cycles;
  int unsigned fail_count;

  fbm_value_noise_unit #(.OCTAVES(NumOctaves)) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .coord_x_i(coord_x_i),
    .coord_y_i(coord_y_i),
    .valid_o(valid_o),
    .noise_value_o(noise_value_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Hash of one lattice corner; the value is bits 23..8 of the mixed word.
  function automatic logic [15:0] lattice_value(input logic [31:0] cx, input logic [31:0] cy);
    logic [31:0] h;
    h = (cx * 32'd374761393) ^ (cy * 32'd668265263);
    h = (h ^ (h >> 13)) * 32'd1274126177;
    h = h ^ (h >> 16);
    return h[23:8];
  endfunction

  function automatic logic [15:0] ease_weight(input logic [15:0] t);
    logic [31:0] sq;
    logic [63:0] p;
    sq = ({16'd0, t} * {16'd0, t}) >> 16;
    p = 64'(sq) * (64'd196608 - 64'(2 * 32'(t)));
    return 16'(p >> 16);
  endfunction

  function automatic logic [15:0] mix(input logic [15:0] a, input logic [15:0] b,
                                      input logic [15:0] w);
    logic [63:0] s;
    s = 64'(a) * (64'd65536 - 64'(w)) + 64'(b) * 64'(w);
    return 16'(s >> 16);
  endfunction

  // One octave: scale, split into cell and fraction, blend the four corners.
  function automatic logic [15:0] octave_level(input logic signed [31:0] x,
                                               input logic signed [31:0] y,
                                               input logic [63:0] freq);
    logic [63:0] px;
    logic [63:0] py;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [15:0] wx;
    logic [15:0] wy;
    logic [15:0] lo;
    logic [15:0] hi;
    px = {{32{x[31]}}, x} * freq;
    py = {{32{y[31]}}, y} * freq;
    cx = px[63:32];
    cy = py[63:32];
    wx = ease_weight(px[31:16]);
    wy = ease_weight(py[31:16]);
    lo = mix(lattice_value(cx, cy), lattice_value(cx + 1, cy), wx);
    hi = mix(lattice_value(cx, cy + 1), lattice_value(cx + 1, cy + 1), wx);
    return mix(lo, hi, wy);
  endfunction

  function automatic logic [15:0] fractal_level(input logic signed [31:0] x,
                                                input logic signed [31:0] y,
                                                input logic [15:0] freq);
    logic [63:0] amps [8];
    logic [63:0] total;
    logic [63:0] norm;
    int n;
    amps = '{64'd65536, 64'd36045, 64'd19825, 64'd10904,
             64'd5997, 64'd3298, 64'd1814, 64'd998};
    total = 0;
    norm = 0;
    n = NumOctaves;
    if (n < 1) n = 1;
    if (n > 8) n = 8;
    for (int o = 0; o < n; o++) begin
      total += amps[o] * 64'(octave_level(x, y, 64'(freq) << o));
      norm += amps[o];
    end
    return 16'((total + norm / 2) / norm);
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $realtime, what);
    fail_count++;
  endtask

  // Results are strobed and cannot be held off, so each strobe is checked as it comes.
  always @(posedge clk_i) begin
    bit bad;
    bit orphan;
    logic [ValW-1:0] want;
    if (rst_ni && valid_o === 1'b1) begin
      levels_sb.check_level(noise_value_o, bad, want, orphan);
      if (orphan) begin
        report_mismatch($sformatf("unexpected level %h", noise_value_o));
      end else if (bad) begin
        report_mismatch($sformatf("level got %h want %h", noise_value_o, want));
      end
    end
  end

  // The watchdog counts cycles in which no word moves in either direction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [31:0] x, input logic [31:0] y);
    start <= 1'b1;
    coord_x_i <= x;
    coord_y_i <= y;
    do @(posedge clk_i); while (busy !== 1'b0);
    levels_sb.note_word(fractal_level(x, y, model_freq));
  endtask

  task automatic pause_sender(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Waits until every expected level has come, then lets the pipeline settle.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk_i);
    while (levels_sb.pending_levels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_frequency(input logic [FreqW-1:0] freq);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= freq;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_freq = freq;
    @(posedge clk_i);
  endtask

  // Coordinates biased toward the extremes, zero, and small Q16.16 values.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return 32'(-$urandom_range(0, 32'h0004_0000));
      3: return 32'($urandom_range(0, 32'h0004_0000));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(input int unsigned words);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < words) begin
      burst = $urandom_range(1, 40);
      for (int unsigned i = 0; i < burst && sent < words; i++) begin
        send_word(pick_coord(), pick_coord());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 30));
    end
  endtask

  initial begin
    logic [FreqW-1:0] freqs [6];
    levels_sb = new();
    fail_count = 0;
    model_freq = FreqReset;
    start <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    coord_x_i <= '0;
    coord_y_i <= '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset frequency: zero, extremes, unit steps.
    send_word(32'h0000_0000, 32'h0000_0000);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(32'h8000_0000, 32'h8000_0000);
    send_word(32'h8000_0000, 32'h7FFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'h0000_0001);
    send_word(32'h0001_0000, 32'hFFFF_0000);
    send_word(32'h0000_FFFF, 32'h0000_8000);
    send_word(32'h5555_5555, 32'hAAAA_AAAA);
    drain_pipeline();

    // Zero frequency collapses every point onto lattice point (0,0).
    write_frequency(16'd0);
    send_word(32'h1234_5678, 32'h8765_4321);
    send_word(32'h8000_0000, 32'h7FFF_FFFF);
    drain_pipeline();

    write_frequency(16'hFFFF);
    send_word(32'h7FFF_FFFF, 32'h8000_0000);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'h0000_8000, 32'h0001_8000);
    drain_pipeline();

    // Random phases across several frequencies, extremes included.
    freqs = '{16'd1, 16'hFFFF, FreqReset, 16'd0, 16'h8000, 16'h0000};
    freqs[5] = 16'($urandom_range(1, 65535));
    foreach (freqs[i]) begin
      write_frequency(freqs[i]);
      random_phase(RandomWords / 6);
      drain_pipeline();
    end

    // An expectation left waiting at the end also counts as a failure.
    if (levels_sb.pending_levels.size() != 0) begin
      report_mismatch($sformatf("%0d levels never came", levels_sb.pending_levels.size()));
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/fbmvn_pkg.sv
rtl/core/fbmvn_octave.sv
rtl/core/fbmvn_cdiv.sv
rtl/core/fbm_value_noise_unit.sv
bench/fbm_value_noise_unit_tb.sv
